>>> hdl/ecu_pkg.sv
// Shared types and constants of the easing curve unit.
`timescale 1ns / 1ps

package ecu_pkg;

  localparam int OP_W     = 4;
  localparam int PROG_W   = 17;
  localparam int EASED_W  = 18;

  // Curve codes; anything above OP_INOUT_BACK returns zero.
  typedef enum logic [OP_W-1:0] {
    OP_IN_SINE     = 4'd0,
    OP_OUT_SINE    = 4'd1,
    OP_INOUT_SINE  = 4'd2,
    OP_IN_CUBIC    = 4'd3,
    OP_OUT_CUBIC   = 4'd4,
    OP_INOUT_CUBIC = 4'd5,
    OP_IN_BACK     = 4'd6,
    OP_OUT_BACK    = 4'd7,
    OP_INOUT_BACK  = 4'd8
  } ecu_op_t;

  // Q16 fixed point
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] HALF_Q16  = 17'd32768;
  localparam logic [17:0] C1_Q16    = 18'd111515;  // overshoot 1.70158
  localparam logic [17:0] C3_Q16    = 18'd177051;  // C1 + 1
  localparam logic [17:0] C2_Q16    = 18'd170060;  // C1 * 1.525
  localparam logic [17:0] C2P1_Q16  = 18'd235596;  // C2 + 1

  // pi/2 in Q30, seed of the quarter-wave table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [EASED_W-1:0] EASED_MAX = 18'sh1FFFF;
  localparam logic signed [EASED_W-1:0] EASED_MIN = 18'sh20000;

endpackage

>>> hdl/ecu_ifs.sv
// Valid/ready channel interfaces of the easing curve unit.
`timescale 1ns / 1ps

interface ecu_in_if;
  logic                           valid;
  logic                           ready;
  logic [ecu_pkg::OP_W-1:0]       operation;
  logic [ecu_pkg::PROG_W-1:0]     progress;

  modport source (output valid, output operation, output progress, input ready);
  modport sink   (input valid, input operation, input progress, output ready);
endinterface

interface ecu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ecu_pkg::EASED_W-1:0]  eased;

  modport source (output valid, output eased, input ready);
  modport sink   (input valid, input eased, output ready);
endinterface

>>> hdl/easing_curve_unit.sv
// Easing curve evaluator: sine, cubic and back curves, signed Q2.16 result.
// An input transaction reaches out_ch through the stage registers, the output register last.
// Throughput: one transaction per cycle; stage 2 holds three multipliers, stages 3 and 4
// two each; the sine table is read in stage 3. A stalled result blocks in_ch only once all
// stages fill. Reset: synchronous, active-low rst_n clears the stage valid bits; payload
// is not reset. The sine table is constant logic, so no clearing pass follows reset.
`timescale 1ns / 1ps

module easing_curve_unit #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input logic         clk,
  input logic         rst_n,
  ecu_in_if.sink      in_ch,
  ecu_out_if.source   out_ch
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W = 16 + IDX_W;
  localparam int NS    = 5;
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(SINE_TABLE_DEPTH);
  localparam logic [63:0]      DEPTH64   = 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0]      RND30     = 64'd536870912;

  // ---------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration by a Taylor series in Q30
  // ---------------------------------------------------------------------------
  logic [16:0] sine_tab [0:SINE_TABLE_DEPTH];
  logic [33:0] sine_row [0:SINE_TABLE_DEPTH];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [63:0] RX  = (ecu_pkg::HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2))
                                  / DEPTH64;
    localparam logic [63:0] RX2 = (RX * RX + RND30) >> 30;
    localparam logic [63:0] RT1 = ((RX  * RX2 + RND30) >> 30) / 64'd6;
    localparam logic [63:0] RT2 = ((RT1 * RX2 + RND30) >> 30) / 64'd20;
    localparam logic [63:0] RT3 = ((RT2 * RX2 + RND30) >> 30) / 64'd42;
    localparam logic [63:0] RT4 = ((RT3 * RX2 + RND30) >> 30) / 64'd72;
    localparam logic [63:0] RT5 = ((RT4 * RX2 + RND30) >> 30) / 64'd110;
    localparam logic [63:0] RT6 = ((RT5 * RX2 + RND30) >> 30) / 64'd156;
    localparam logic [63:0] RT7 = ((RT6 * RX2 + RND30) >> 30) / 64'd210;
    localparam logic [63:0] RT8 = ((RT7 * RX2 + RND30) >> 30) / 64'd272;
    localparam logic signed [63:0] RSUM = $signed(RX) - $signed(RT1) + $signed(RT2)
                                        - $signed(RT3) + $signed(RT4) - $signed(RT5)
                                        + $signed(RT6) - $signed(RT7) + $signed(RT8);
    localparam logic signed [63:0] RE = (RSUM + 64'sd8192) >>> 14;
    localparam logic [16:0] RV = (RE < 64'sd0) ? 17'd0 :
                                 (RE > 64'sd65536) ? ecu_pkg::ONE_Q16 : RE[16:0];
    assign sine_tab[i] = RV;
  end

  // Each row holds an entry and its upper neighbour; the last row repeats itself.
  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_row
    if (i < SINE_TABLE_DEPTH) begin : g_mid
      assign sine_row[i] = {sine_tab[i], sine_tab[i+1]};
    end else begin : g_end
      assign sine_row[i] = {sine_tab[i], sine_tab[i]};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control
  // ---------------------------------------------------------------------------
  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_nxt;
  logic [NS-1:0] stage_go;

  always_comb begin
    stage_go[NS-1] = !valid_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_go[k] = !valid_r[k] || stage_go[k+1];
    end
    valid_nxt[0] = stage_go[0] ? in_ch.valid : valid_r[0];
    for (int k = 1; k < NS; k++) begin
      if (stage_go[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ch.ready  = stage_go[0];
  assign out_ch.valid = valid_r[NS-1];

  // ---------------------------------------------------------------------------
  // Stage 1: clamp progress, form sine argument and polynomial base
  // ---------------------------------------------------------------------------
  logic [16:0]        prog_cl;
  logic [17:0]        two_t;
  logic [16:0]        one_minus_t;
  logic [16:0]        s1_arg_nxt;
  logic               s1_neg_nxt;
  logic signed [17:0] s1_x_nxt;

  logic [3:0]         s1_op_r;
  logic               s1_half_r;
  logic               s1_neg_r;
  logic [16:0]        s1_arg_r;
  logic signed [17:0] s1_x_r;

  always_comb begin
    prog_cl     = (in_ch.progress > ecu_pkg::ONE_Q16) ? ecu_pkg::ONE_Q16 : in_ch.progress;
    two_t       = {prog_cl, 1'b0};
    one_minus_t = ecu_pkg::ONE_Q16 - prog_cl;
    s1_arg_nxt  = prog_cl;
    s1_neg_nxt  = 1'b0;
    s1_x_nxt    = '0;
    case (in_ch.operation)
      ecu_pkg::OP_IN_SINE: begin
        s1_arg_nxt = one_minus_t;
      end
      ecu_pkg::OP_OUT_SINE: begin
        s1_arg_nxt = prog_cl;
      end
      ecu_pkg::OP_INOUT_SINE: begin
        if (prog_cl <= ecu_pkg::HALF_Q16) begin
          s1_arg_nxt = 17'({1'b0, ecu_pkg::ONE_Q16} - two_t);
        end else begin
          s1_arg_nxt = 17'(two_t - {1'b0, ecu_pkg::ONE_Q16});
          s1_neg_nxt = 1'b1;
        end
      end
      ecu_pkg::OP_IN_CUBIC: begin
        s1_x_nxt = $signed({1'b0, prog_cl});
      end
      ecu_pkg::OP_OUT_CUBIC: begin
        s1_x_nxt = $signed({1'b0, one_minus_t});
      end
      ecu_pkg::OP_INOUT_CUBIC: begin
        if (prog_cl < ecu_pkg::HALF_Q16) begin
          s1_x_nxt = $signed({1'b0, prog_cl});
        end else begin
          s1_x_nxt = $signed({1'b0, one_minus_t[15:0], 1'b0});
        end
      end
      ecu_pkg::OP_IN_BACK: begin
        s1_x_nxt = $signed({1'b0, prog_cl});
      end
      ecu_pkg::OP_OUT_BACK: begin
        s1_x_nxt = $signed({1'b0, prog_cl}) - $signed({1'b0, ecu_pkg::ONE_Q16});
      end
      ecu_pkg::OP_INOUT_BACK: begin
        if (prog_cl < ecu_pkg::HALF_Q16) begin
          s1_x_nxt = $signed(two_t);
        end else begin
          s1_x_nxt = $signed(two_t - {ecu_pkg::ONE_Q16, 1'b0});
        end
      end
      default: begin
        s1_x_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_go[0]) begin
      s1_op_r   <= in_ch.operation;
      s1_half_r <= prog_cl < ecu_pkg::HALF_Q16;
      s1_neg_r  <= s1_neg_nxt;
      s1_arg_r  <= s1_arg_nxt;
      s1_x_r    <= s1_x_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: table position, square of the base, C2+1 product
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]   s2_pos;
  logic signed [35:0] s2_sq_full;
  logic signed [36:0] s2_cx_full;

  logic [3:0]         s2_op_r;
  logic               s2_half_r;
  logic               s2_neg_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [15:0]        s2_frac_r;
  logic [32:0]        s2_sq_r;
  logic signed [34:0] s2_cx_r;
  logic signed [17:0] s2_x_r;

  always_comb begin
    s2_pos     = POS_W'(s1_arg_r) * DEPTH_POS;
    s2_sq_full = s1_x_r * s1_x_r;
    s2_cx_full = $signed({1'b0, ecu_pkg::C2P1_Q16}) * s1_x_r;
  end

  always_ff @(posedge clk) begin
    if (stage_go[1]) begin
      s2_op_r   <= s1_op_r;
      s2_half_r <= s1_half_r;
      s2_neg_r  <= s1_neg_r;
      s2_idx_r  <= s2_pos[16 +: IDX_W];
      s2_frac_r <= s2_pos[15:0];
      s2_sq_r   <= s2_sq_full[32:0];
      s2_cx_r   <= s2_cx_full[34:0];
      s2_x_r    <= s1_x_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: table read, cube or second back product, C1 product
  // ---------------------------------------------------------------------------
  logic               s3_cubic;
  logic [33:0]        s3_sq_rnd;
  logic [16:0]        s3_a2;
  logic signed [34:0] s3_cx_rnd;
  logic signed [18:0] s3_cx_q;
  logic signed [18:0] s3_inner;
  logic signed [33:0] s3_mul_a;
  logic signed [18:0] s3_mul_b;
  logic signed [52:0] s3_prod_full;
  logic [33:0]        s3_q2_full;

  logic [3:0]         s3_op_r;
  logic               s3_half_r;
  logic               s3_neg_r;
  logic [15:0]        s3_frac_r;
  logic [33:0]        s3_row_r;
  logic signed [49:0] s3_prod_r;
  logic [32:0]        s3_q2_r;

  always_comb begin
    s3_cubic  = (s2_op_r == ecu_pkg::OP_IN_CUBIC) || (s2_op_r == ecu_pkg::OP_OUT_CUBIC) ||
                (s2_op_r == ecu_pkg::OP_INOUT_CUBIC);
    s3_sq_rnd = {1'b0, s2_sq_r} + 34'd32768;
    s3_a2     = s3_sq_rnd[32:16];
    s3_cx_rnd = s2_cx_r + 35'sd32768;
    s3_cx_q   = $signed(s3_cx_rnd[34:16]);
    if (s2_half_r) begin
      s3_inner = s3_cx_q - $signed({1'b0, ecu_pkg::C2_Q16});
    end else begin
      s3_inner = s3_cx_q + $signed({1'b0, ecu_pkg::C2_Q16});
    end
    // Cubes keep the full square; back curves multiply its rounded value.
    if (s3_cubic) begin
      s3_mul_a = $signed({1'b0, s2_sq_r});
    end else begin
      s3_mul_a = $signed({17'b0, s3_a2});
    end
    if (s2_op_r == ecu_pkg::OP_INOUT_BACK) begin
      s3_mul_b = s3_inner;
    end else begin
      s3_mul_b = {s2_x_r[17], s2_x_r};
    end
    s3_prod_full = s3_mul_a * s3_mul_b;
    s3_q2_full   = {16'b0, ecu_pkg::C1_Q16} * {17'b0, s3_a2};
  end

  always_ff @(posedge clk) begin
    if (stage_go[2]) begin
      s3_op_r   <= s2_op_r;
      s3_half_r <= s2_half_r;
      s3_neg_r  <= s2_neg_r;
      s3_frac_r <= s2_frac_r;
      s3_row_r  <= sine_row[s2_idx_r];
      s3_prod_r <= s3_prod_full[49:0];
      s3_q2_r   <= s3_q2_full[32:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sine interpolation, cubic rounding, C3 product
  // ---------------------------------------------------------------------------
  logic [16:0]        s4_t0;
  logic [16:0]        s4_t1;
  logic signed [17:0] s4_diff;
  logic signed [35:0] s4_ip;
  logic signed [35:0] s4_ip_rnd;
  logic signed [18:0] s4_s_full;
  logic [49:0]        s4_cube_a;
  logic [49:0]        s4_cube_b;
  logic [49:0]        s4_cube_c;
  logic signed [49:0] s4_prnd;
  logic signed [18:0] s4_r2;
  logic signed [20:0] s4_r2e;
  logic signed [37:0] s4_p3_full;
  logic [33:0]        s4_q_rnd;
  logic signed [20:0] s4_early_nxt;

  logic [3:0]         s4_op_r;
  logic               s4_neg_r;
  logic [16:0]        s4_s_r;
  logic signed [20:0] s4_early_r;
  logic signed [34:0] s4_p3_r;
  logic [16:0]        s4_qr_r;

  always_comb begin
    s4_t0      = s3_row_r[33:17];
    s4_t1      = s3_row_r[16:0];
    s4_diff    = $signed({1'b0, s4_t1}) - $signed({1'b0, s4_t0});
    s4_ip      = s4_diff * $signed({1'b0, s3_frac_r});
    s4_ip_rnd  = s4_ip + 36'sd32768;
    s4_s_full  = $signed({2'b0, s4_t0}) + $signed(s4_ip_rnd[34:16]);

    s4_cube_a  = {1'b0, s3_prod_r[48:0]} + (50'd1 << 31);
    s4_cube_b  = {1'b0, s3_prod_r[48:0]} + (50'd1 << 29);
    s4_cube_c  = {1'b0, s3_prod_r[48:0]} + (50'd1 << 32);

    s4_prnd    = s3_prod_r + 50'sd32768;
    s4_r2      = $signed(s4_prnd[34:16]);
    s4_r2e     = {{2{s4_r2[18]}}, s4_r2};
    s4_p3_full = $signed({1'b0, ecu_pkg::C3_Q16}) * s4_r2;
    s4_q_rnd   = {1'b0, s3_q2_r} + 34'd32768;

    case (s3_op_r)
      ecu_pkg::OP_IN_CUBIC: begin
        s4_early_nxt = $signed({3'b0, s4_cube_a[49:32]});
      end
      ecu_pkg::OP_OUT_CUBIC: begin
        s4_early_nxt = $signed({4'b0, ecu_pkg::ONE_Q16}) - $signed({3'b0, s4_cube_a[49:32]});
      end
      ecu_pkg::OP_INOUT_CUBIC: begin
        if (s3_half_r) begin
          s4_early_nxt = $signed({1'b0, s4_cube_b[49:30]});
        end else begin
          s4_early_nxt = $signed({4'b0, ecu_pkg::ONE_Q16})
                       - $signed({4'b0, s4_cube_c[49:33]});
        end
      end
      ecu_pkg::OP_INOUT_BACK: begin
        if (s3_half_r) begin
          s4_early_nxt = (s4_r2e + 21'sd1) >>> 1;
        end else begin
          s4_early_nxt = (s4_r2e + 21'sd131073) >>> 1;
        end
      end
      default: begin
        s4_early_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_go[3]) begin
      s4_op_r    <= s3_op_r;
      s4_neg_r   <= s3_neg_r;
      s4_s_r     <= s4_s_full[16:0];
      s4_early_r <= s4_early_nxt;
      s4_p3_r    <= s4_p3_full[34:0];
      s4_qr_r    <= s4_q_rnd[32:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: combine per curve, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [34:0] s5_p3_rnd;
  logic signed [20:0] s5_p3q;
  logic signed [20:0] s5_s;
  logic signed [20:0] s5_qr;
  logic signed [20:0] s5_one;
  logic signed [20:0] s5_mid;
  logic signed [20:0] s5_res;
  logic signed [17:0] eased_nxt;
  logic signed [17:0] eased_r;

  always_comb begin
    s5_p3_rnd = s4_p3_r + 35'sd32768;
    s5_p3q    = {{2{s5_p3_rnd[34]}}, s5_p3_rnd[34:16]};
    s5_s      = $signed({4'b0, s4_s_r});
    s5_qr     = $signed({4'b0, s4_qr_r});
    s5_one    = $signed({4'b0, ecu_pkg::ONE_Q16});
    // Cosine of the half wave is minus the table value past the midpoint.
    if (s4_neg_r) begin
      s5_mid = s5_one + 21'sd1 + s5_s;
    end else begin
      s5_mid = s5_one + 21'sd1 - s5_s;
    end
    case (s4_op_r)
      ecu_pkg::OP_IN_SINE:     s5_res = s5_one - s5_s;
      ecu_pkg::OP_OUT_SINE:    s5_res = s5_s;
      ecu_pkg::OP_INOUT_SINE:  s5_res = s5_mid >>> 1;
      ecu_pkg::OP_IN_CUBIC:    s5_res = s4_early_r;
      ecu_pkg::OP_OUT_CUBIC:   s5_res = s4_early_r;
      ecu_pkg::OP_INOUT_CUBIC: s5_res = s4_early_r;
      ecu_pkg::OP_IN_BACK:     s5_res = s5_p3q - s5_qr;
      ecu_pkg::OP_OUT_BACK:    s5_res = s5_one + s5_p3q + s5_qr;
      ecu_pkg::OP_INOUT_BACK:  s5_res = s4_early_r;
      default:                 s5_res = '0;
    endcase
    if (s5_res > 21'(ecu_pkg::EASED_MAX)) begin
      eased_nxt = ecu_pkg::EASED_MAX;
    end else if (s5_res < 21'(ecu_pkg::EASED_MIN)) begin
      eased_nxt = ecu_pkg::EASED_MIN;
    end else begin
      eased_nxt = s5_res[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go[4]) begin
      eased_r <= eased_nxt;
    end
  end

  assign out_ch.eased = eased_r;

`ifndef SYNTHESIS
  // Input back-pressure only when every stage is full and the result waits.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready == ((&valid_r) && !out_ch.ready))
    else $error("in_ch.ready disagrees with pipeline occupancy");

  // Interpolated table value stays within one.
  a_sine_span: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[3] && (s4_op_r == ecu_pkg::OP_IN_SINE || s4_op_r == ecu_pkg::OP_OUT_SINE ||
                   s4_op_r == ecu_pkg::OP_INOUT_SINE)
    |-> s4_s_r <= ecu_pkg::ONE_Q16)
    else $error("interpolated sine above one");

  // Sine and cubic curves never leave [0, 1].
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[3] && stage_go[4] &&
    (s4_op_r == ecu_pkg::OP_IN_SINE || s4_op_r == ecu_pkg::OP_OUT_SINE ||
     s4_op_r == ecu_pkg::OP_INOUT_SINE || s4_op_r == ecu_pkg::OP_IN_CUBIC ||
     s4_op_r == ecu_pkg::OP_OUT_CUBIC || s4_op_r == ecu_pkg::OP_INOUT_CUBIC)
    |=> (eased_r >= 18'sd0) && (eased_r <= 18'sd65536))
    else $error("sine or cubic result outside unit range");
`endif

endmodule
